>>> rtl/core/blw_pkg.sv
package blw_pkg;

    // Fixed field widths
    localparam int POS_W   = 9;   // major/minor positions, deltas, columns
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int COLOR_W = 16;
    localparam int ERR_W   = 12;  // two's complement error term

    localparam int DEF_COLOR_BITS = 16;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Line walk state: everything but the color
    typedef struct packed {
        logic             steep;      // y is the major axis
        logic             minor_neg;  // minor coordinate decreases
        logic [POS_W-1:0] maj_pos;
        logic [POS_W-1:0] min_pos;
        logic [POS_W-1:0] maj_end;
        logic [POS_W-1:0] maj_delta;
        logic [POS_W-1:0] min_delta;
        logic [ERR_W-1:0] err;
    } t_line;

    // One pixel write word
    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

endpackage

>>> rtl/core/blw_setup.sv
module blw_setup (
    input  logic [blw_pkg::X_W-1:0] i_x_start,
    input  logic [blw_pkg::Y_W-1:0] i_y_start,
    input  logic [blw_pkg::X_W-1:0] i_x_end,
    input  logic [blw_pkg::Y_W-1:0] i_y_end,
    output blw_pkg::t_line          o_line
);
    import blw_pkg::*;

    logic [POS_W-1:0] xa, xb, ya, yb;
    logic [POS_W-1:0] adx, ady;
    logic [POS_W-1:0] maj0, min0, maj1, min1;
    logic             steep;
    logic             neg;
    logic [POS_W-1:0] maj_d, min_d;

    // Absolute deltas and major axis (y wins a tie)
    always_comb begin
        xa    = i_x_start;
        xb    = i_x_end;
        ya    = POS_W'(i_y_start);
        yb    = POS_W'(i_y_end);
        adx   = (xb > xa) ? (xb - xa) : (xa - xb);
        ady   = (yb > ya) ? (yb - ya) : (ya - yb);
        steep = !(ady < adx);
    end

    // Order endpoints so the major coordinate increases
    always_comb begin
        if (!steep) begin
            if (xa > xb) begin
                maj0 = xb; min0 = yb; maj1 = xa; min1 = ya;
            end else begin
                maj0 = xa; min0 = ya; maj1 = xb; min1 = yb;
            end
        end else begin
            if (ya > yb) begin
                maj0 = yb; min0 = xb; maj1 = ya; min1 = xa;
            end else begin
                maj0 = ya; min0 = xa; maj1 = yb; min1 = xb;
            end
        end
        neg   = (min1 < min0);
        maj_d = maj1 - maj0;
        min_d = neg ? (min0 - min1) : (min1 - min0);
    end

    // Initial error: 2*minor_delta - major_delta
    always_comb begin
        o_line.steep     = steep;
        o_line.minor_neg = neg;
        o_line.maj_pos   = maj0;
        o_line.min_pos   = min0;
        o_line.maj_end   = maj1;
        o_line.maj_delta = maj_d;
        o_line.min_delta = min_d;
        o_line.err       = ERR_W'({min_d, 1'b0}) - ERR_W'(maj_d);
    end

endmodule

>>> rtl/core/blw_walker.sv
module blw_walker #(
    parameter int COLOR_BITS = blw_pkg::DEF_COLOR_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,       // word taken this cycle
    input  logic                        i_command,
    input  blw_pkg::t_line              i_setup,
    input  logic [blw_pkg::COLOR_W-1:0] i_color,
    output logic                        o_valid,    // word yields a pixel
    output blw_pkg::t_pixel             o_pixel
);
    import blw_pkg::*;

    localparam int CW = (COLOR_BITS < COLOR_W) ? COLOR_BITS : COLOR_W;

    logic          r_active;
    t_line         r_line;
    logic [CW-1:0] r_color;

    logic          start;
    t_line         cur;
    t_line         adv;
    logic [CW-1:0] cur_color;
    logic          last;
    logic          err_pos;

    // Current line: fresh setup on start, held state on step
    always_comb begin
        start     = (i_command == CMD_START);
        cur       = start ? i_setup : r_line;
        cur_color = start ? i_color[CW-1:0] : r_color;
        last      = (cur.maj_pos == cur.maj_end);
        o_valid   = start || r_active;
    end

    // Pixel of the current position
    always_comb begin
        o_pixel.x     = cur.steep ? cur.min_pos : cur.maj_pos;
        o_pixel.y     = cur.steep ? cur.maj_pos[Y_W-1:0] : cur.min_pos[Y_W-1:0];
        o_pixel.color = COLOR_W'(cur_color);
        o_pixel.last  = last;
    end

    // One Bresenham step; minor moves only on a strictly positive error
    always_comb begin
        adv     = cur;
        err_pos = !cur.err[ERR_W-1] && (cur.err != '0);
        if (err_pos) begin
            adv.min_pos = cur.minor_neg ? (cur.min_pos - 1'b1) : (cur.min_pos + 1'b1);
            adv.err     = cur.err + ERR_W'({cur.min_delta, 1'b0})
                                  - ERR_W'({cur.maj_delta, 1'b0});
        end else begin
            adv.err     = cur.err + ERR_W'({cur.min_delta, 1'b0});
        end
        adv.maj_pos = cur.maj_pos + 1'b1;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_go && o_valid) begin
            r_active <= !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && o_valid) begin
            r_line  <= last ? cur : adv;
            r_color <= cur_color;
        end
    end

endmodule

>>> rtl/core/blw_out_buf.sv
module blw_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  blw_pkg::t_pixel i_pixel,
    output logic            o_space,      // can take a word this cycle
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output blw_pkg::t_pixel o_pixel
);
    import blw_pkg::*;

    logic   r_out_valid;
    t_pixel r_out;
    logic   r_skid_valid;
    t_pixel r_skid;
    logic   take;

    assign o_space     = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out;
    assign take        = r_out_valid && i_out_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid) begin
            r_out_valid  <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Data: skid drains first, new word lands in the first free slot
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : i_pixel;
        end else if (!r_out_valid) begin
            r_out <= i_pixel;
        end else if (i_push) begin
            r_skid <= i_pixel;
        end
    end

endmodule

>>> rtl/core/bresenham_line_walker.sv
// Bresenham line walker: a start word latches two endpoints and a color and
// yields the first pixel; each step word yields the next pixel, the far
// endpoint flagged as last, after which steps yield nothing until the next
// start. A start during a line drops that line. One word is taken every clock
// while the result buffer has room; a word's pixel passes the input register,
// then the setup/step logic into the result register. A two-entry result
// buffer takes the pixel of a word that arrives while the sink stalls; once its
// second entry is in use the input pauses until the sink drains it.
module bresenham_line_walker #(
    parameter int COLOR_BITS = blw_pkg::DEF_COLOR_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [blw_pkg::X_W-1:0]     i_x_start,
    input  logic [blw_pkg::Y_W-1:0]     i_y_start,
    input  logic [blw_pkg::X_W-1:0]     i_x_end,
    input  logic [blw_pkg::Y_W-1:0]     i_y_end,
    input  logic [blw_pkg::COLOR_W-1:0] i_line_color,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [blw_pkg::X_W-1:0]     o_pixel_x,
    output logic [blw_pkg::Y_W-1:0]     o_pixel_y,
    output logic [blw_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                        o_last_pixel
);
    import blw_pkg::*;

    logic               r_in_valid;
    logic               r_command;
    logic [X_W-1:0]     r_x_start;
    logic [Y_W-1:0]     r_y_start;
    logic [X_W-1:0]     r_x_end;
    logic [Y_W-1:0]     r_y_end;
    logic [COLOR_W-1:0] r_color;

    t_line  setup;
    logic   buf_space;
    logic   go;
    logic   pix_valid;
    t_pixel pix;
    t_pixel out_pix;

    assign go         = r_in_valid && buf_space;
    assign o_in_ready = !r_in_valid || buf_space;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_command <= i_command;
            r_x_start <= i_x_start;
            r_y_start <= i_y_start;
            r_x_end   <= i_x_end;
            r_y_end   <= i_y_end;
            r_color   <= i_line_color;
        end
    end

    blw_setup u_setup (
        .i_x_start (r_x_start),
        .i_y_start (r_y_start),
        .i_x_end   (r_x_end),
        .i_y_end   (r_y_end),
        .o_line    (setup)
    );

    blw_walker #(
        .COLOR_BITS (COLOR_BITS)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_command (r_command),
        .i_setup   (setup),
        .i_color   (r_color),
        .o_valid   (pix_valid),
        .o_pixel   (pix)
    );

    blw_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (go && pix_valid),
        .i_pixel     (pix),
        .o_space     (buf_space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel     (out_pix)
    );

    assign o_pixel_x     = out_pix.x;
    assign o_pixel_y     = out_pix.y;
    assign o_pixel_color = out_pix.color;
    assign o_last_pixel  = out_pix.last;

endmodule
